@@ src/ps2_set2_key_decoder_defines.svh @@
// assertion macros for the ps2 set 2 key decoder
`ifndef PS2_SET2_KEY_DECODER_DEFINES_SVH
`define PS2_SET2_KEY_DECODER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PS2K_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ps2k check failed");
// next-cycle implication
`define PS2K_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ps2k check failed");
`endif

@@ src/ps2k_pkg.sv @@
// shared types, constants and scan code tables for the key decoder
`timescale 1ns / 1ps
`default_nettype none
package ps2k_pkg;
	localparam logic [7:0] PFX_EXT   = 8'hE0;
	localparam logic [7:0] PFX_REL   = 8'hF0;
	localparam logic [7:0] SC_LSHIFT = 8'h12;
	localparam logic [7:0] SC_RSHIFT = 8'h59;
	localparam logic [7:0] SC_CTRL   = 8'h14;
	localparam logic [7:0] SC_ALT    = 8'h11;
	localparam logic [7:0] B_ACK     = 8'hFA;
	localparam logic [7:0] B_RESEND  = 8'hFE;
	localparam logic [7:0] B_SELFOK  = 8'hAA;
	localparam logic [6:0] CH_CTRL_C = 7'h03;
	localparam logic [6:0] CH_CTRL_V = 7'h16;
	localparam logic [6:0] CH_SPACE  = 7'h20;

	localparam logic [1:0] REG_LAYOUT = 2'd0;
	localparam logic [1:0] REG_REP_EN = 2'd1;
	localparam logic [1:0] REG_DELAY  = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_NAV     = 2'd1;
	localparam logic [1:0] KIND_CONSOLE = 2'd2;

	// classified beat passed from front to back
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_MAKE  = 2'd1,
		CMD_BREAK = 2'd2,
		CMD_EXT   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] code;
	} item_t;

	function automatic logic [6:0] map_plain(input logic [6:0] c);
		logic [6:0] r;
		case (c)
			7'h0E: r = 7'h60; 7'h16: r = 7'h31; 7'h1E: r = 7'h32; 7'h26: r = 7'h33;
			7'h25: r = 7'h34; 7'h2E: r = 7'h35; 7'h36: r = 7'h36; 7'h3D: r = 7'h37;
			7'h3E: r = 7'h38; 7'h46: r = 7'h39; 7'h45: r = 7'h30; 7'h4E: r = 7'h2D;
			7'h55: r = 7'h3D; 7'h66: r = 7'h08; 7'h0D: r = 7'h09; 7'h5A: r = 7'h0A;
			7'h15: r = 7'h71; 7'h1D: r = 7'h77; 7'h24: r = 7'h65; 7'h2D: r = 7'h72;
			7'h2C: r = 7'h74; 7'h35: r = 7'h79; 7'h3C: r = 7'h75; 7'h43: r = 7'h69;
			7'h44: r = 7'h6F; 7'h4D: r = 7'h70; 7'h54: r = 7'h5B; 7'h5B: r = 7'h5D;
			7'h1C: r = 7'h61; 7'h1B: r = 7'h73; 7'h23: r = 7'h64; 7'h2B: r = 7'h66;
			7'h34: r = 7'h67; 7'h33: r = 7'h68; 7'h3B: r = 7'h6A; 7'h42: r = 7'h6B;
			7'h4B: r = 7'h6C; 7'h4C: r = 7'h3B; 7'h52: r = 7'h27; 7'h5D: r = 7'h5C;
			7'h1A: r = 7'h7A; 7'h22: r = 7'h78; 7'h21: r = 7'h63; 7'h2A: r = 7'h76;
			7'h32: r = 7'h62; 7'h31: r = 7'h6E; 7'h3A: r = 7'h6D; 7'h41: r = 7'h2C;
			7'h49: r = 7'h2E; 7'h4A: r = 7'h2F; 7'h29: r = 7'h20;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] map_shifted(input logic [6:0] c);
		logic [6:0] r;
		case (c)
			7'h0E: r = 7'h7E; 7'h16: r = 7'h21; 7'h1E: r = 7'h40; 7'h26: r = 7'h23;
			7'h25: r = 7'h24; 7'h2E: r = 7'h25; 7'h36: r = 7'h5E; 7'h3D: r = 7'h26;
			7'h3E: r = 7'h2A; 7'h46: r = 7'h28; 7'h45: r = 7'h29; 7'h4E: r = 7'h5F;
			7'h55: r = 7'h2B; 7'h66: r = 7'h08; 7'h0D: r = 7'h09; 7'h5A: r = 7'h0A;
			7'h15: r = 7'h51; 7'h1D: r = 7'h57; 7'h24: r = 7'h45; 7'h2D: r = 7'h52;
			7'h2C: r = 7'h54; 7'h35: r = 7'h59; 7'h3C: r = 7'h55; 7'h43: r = 7'h49;
			7'h44: r = 7'h4F; 7'h4D: r = 7'h50; 7'h54: r = 7'h7B; 7'h5B: r = 7'h7D;
			7'h1C: r = 7'h41; 7'h1B: r = 7'h53; 7'h23: r = 7'h44; 7'h2B: r = 7'h46;
			7'h34: r = 7'h47; 7'h33: r = 7'h48; 7'h3B: r = 7'h4A; 7'h42: r = 7'h4B;
			7'h4B: r = 7'h4C; 7'h4C: r = 7'h3A; 7'h52: r = 7'h22; 7'h5D: r = 7'h7C;
			7'h1A: r = 7'h5A; 7'h22: r = 7'h58; 7'h21: r = 7'h43; 7'h2A: r = 7'h56;
			7'h32: r = 7'h42; 7'h31: r = 7'h4E; 7'h3A: r = 7'h4D; 7'h41: r = 7'h3C;
			7'h49: r = 7'h3E; 7'h4A: r = 7'h3F; 7'h29: r = 7'h20;
			default: r = 7'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ src/ps2k_front.sv @@
// front end: drops noise bytes, tracks prefixes, classifies each beat
`timescale 1ns / 1ps
`default_nettype none
module ps2k_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	output logic                ready,
	input  wire logic           operation,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           from_aux,
	input  wire logic           line_error,
	output logic                q_valid,
	input  wire logic           q_ready,
	output ps2k_pkg::item_t     q_item
);
	import ps2k_pkg::*;

	logic ext_q, rel_q;
	logic acc, drop, is_pfx;

	assign ready = q_ready;
	assign acc   = valid && ready;
	assign drop  = !operation && (from_aux || line_error || rx_byte == B_ACK
		|| rx_byte == B_RESEND || rx_byte == B_SELFOK || rx_byte == 8'h00);
	assign is_pfx = !operation && (rx_byte == PFX_EXT || rx_byte == PFX_REL);

	assign q_valid = valid && !drop && !is_pfx;
	always_comb begin
		q_item.code = rx_byte;
		if (operation)
			q_item.cmd = CMD_TICK;
		else if (rel_q)
			q_item.cmd = CMD_BREAK;
		else if (ext_q)
			q_item.cmd = CMD_EXT;
		else
			q_item.cmd = CMD_MAKE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
			rel_q <= 1'b0;
		end else if (acc && !operation && !drop) begin
			if (rx_byte == PFX_EXT) begin
				ext_q <= 1'b1;
			end else if (rx_byte == PFX_REL) begin
				rel_q <= 1'b1;
			end else begin
				// any key byte consumes both prefixes
				ext_q <= 1'b0;
				rel_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/ps2k_fifo.sv @@
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_set2_key_decoder_defines.svh"
module ps2k_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ps2k_pkg::item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ps2k_pkg::item_t     out_item
);
	import ps2k_pkg::*;

	item_t mem_q [2];
	logic  wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`PS2K_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`PS2K_ASSERT_NXT(a_full_hold, clk, arst_n, cnt_q == 2'd2 && !pop, cnt_q == 2'd2)
	`PS2K_ASSERT_IMP(a_ptr_agree, clk, arst_n, cnt_q != 2'd1, wr_q == rd_q)
endmodule
`default_nettype wire

@@ src/ps2k_back.sv @@
// back end: modifier state, table lookup, typematic repeat, output register
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_set2_key_decoder_defines.svh"
module ps2k_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ps2k_pkg::item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          event_kind,
	output logic [6:0]          event_value
);
	import ps2k_pkg::*;

	logic        rep_en_q;
	logic [15:0] delay_q, period_q;
	logic shift_q, ctrl_q, alt_q, latch_q, layout_q;
	logic [7:0]  rscan_q;
	logic [6:0]  rchar_q;
	logic        armed_q;
	logic [15:0] cnt_q;
	logic        ov_q;
	logic [1:0]  ok_q;
	logic [6:0]  ov_val_q;

	logic go, code_shift;
	logic        emit;
	logic [1:0]  kind;
	logic [6:0]  val, ch;
	logic [7:0]  b;

	assign in_ready  = !ov_q || out_ready;
	assign go        = in_valid && in_ready;
	assign out_valid = ov_q;
	assign event_kind  = ok_q;
	assign event_value = ov_val_q;
	assign b = in_item.code;
	assign code_shift = b == SC_LSHIFT || b == SC_RSHIFT;

	always_comb begin
		ch = shift_q ? map_shifted(b[6:0]) : map_plain(b[6:0]);
		if (b[7])
			ch = 7'h00;
		else if (layout_q && b == 8'h35)
			ch = shift_q ? 7'h5A : 7'h7A;
		else if (layout_q && b == 8'h1A)
			ch = shift_q ? 7'h59 : 7'h79;
	end

	always_comb begin
		emit = 1'b0;
		kind = KIND_CHAR;
		val  = ch;
		case (in_item.cmd)
			CMD_TICK: begin
				emit = rep_en_q && armed_q && cnt_q <= 16'd1;
				val  = rchar_q;
			end
			CMD_EXT: begin
				kind = KIND_NAV;
				emit = 1'b1;
				case (b)
					8'h6B: val = 7'd0;
					8'h74: val = 7'd1;
					8'h75: val = 7'd2;
					8'h72: val = 7'd3;
					8'h7D: val = 7'd4;
					8'h7A: val = 7'd5;
					default: emit = 1'b0;
				endcase
			end
			CMD_MAKE: begin
				if (code_shift || b == SC_CTRL || b == SC_ALT) begin
					emit = 1'b0;
				end else if (alt_q && (b == 8'h05 || b == 8'h06 || b == 8'h04
					|| b == 8'h0C)) begin
					emit = 1'b1;
					kind = KIND_CONSOLE;
					val  = (b == 8'h05) ? 7'd0 : (b == 8'h06) ? 7'd1
						: (b == 8'h04) ? 7'd2 : 7'd3;
				end else begin
					emit = ch != 7'h00;
					if (ctrl_q && (ch == 7'h63 || ch == 7'h43))
						val = CH_CTRL_C;
					else if (ctrl_q && (ch == 7'h76 || ch == 7'h56))
						val = CH_CTRL_V;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			ok_q     <= kind;
			ov_val_q <= val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_en_q <= 1'b1;
			delay_q  <= 16'd50;
			period_q <= 16'd10;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			latch_q  <= 1'b0;
			layout_q <= 1'b0;
			rscan_q  <= 8'h00;
			rchar_q  <= 7'h00;
			armed_q  <= 1'b0;
			cnt_q    <= 16'd0;
			ov_q     <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (go && emit) ov_q <= 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					REG_LAYOUT: layout_q <= cfg_data[0];
					REG_REP_EN: rep_en_q <= cfg_data[0];
					REG_DELAY:  delay_q  <= cfg_data;
					REG_PERIOD: period_q <= cfg_data;
					default: ;
				endcase
			end
			if (go) begin
				case (in_item.cmd)
					CMD_TICK: begin
						if (rep_en_q && armed_q) begin
							if (cnt_q > 16'd1)
								cnt_q <= cnt_q - 16'd1;
							else
								cnt_q <= (period_q == 16'd0) ? 16'd1 : period_q;
						end
					end
					CMD_BREAK: begin
						if (code_shift) shift_q <= 1'b0;
						if (b == SC_CTRL) ctrl_q <= 1'b0;
						if (b == SC_ALT) alt_q <= 1'b0;
						if (armed_q && b == rscan_q) begin
							armed_q <= 1'b0;
							rscan_q <= 8'h00;
							rchar_q <= 7'h00;
							cnt_q   <= 16'd0;
						end
						// toggle latch survives only while shift and alt both stay down
						if (!((shift_q && !code_shift) && (alt_q && b != SC_ALT)))
							latch_q <= 1'b0;
					end
					CMD_MAKE: begin
						if (code_shift) begin
							shift_q <= 1'b1;
							if (alt_q && !latch_q) begin
								layout_q <= !layout_q;
								latch_q  <= 1'b1;
							end
						end else if (b == SC_CTRL) begin
							ctrl_q <= 1'b1;
						end else if (b == SC_ALT) begin
							alt_q <= 1'b1;
							if (shift_q && !latch_q) begin
								layout_q <= !layout_q;
								latch_q  <= 1'b1;
							end
						end else if (emit && kind == KIND_CHAR && val == ch) begin
							if (ch >= CH_SPACE && rep_en_q) begin
								armed_q <= 1'b1;
								rscan_q <= b;
								rchar_q <= ch;
								cnt_q   <= (delay_q == 16'd0) ? 16'd1 : delay_q;
							end else begin
								armed_q <= 1'b0;
								rscan_q <= 8'h00;
								rchar_q <= 7'h00;
								cnt_q   <= 16'd0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	`PS2K_ASSERT_NXT(a_emit_shows, clk, arst_n, go && emit, out_valid)
	`PS2K_ASSERT_IMP(a_armed_char, clk, arst_n, armed_q, rchar_q >= CH_SPACE)
	`PS2K_ASSERT_NXT(a_hold_out, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(event_value) && $stable(event_kind))
endmodule
`default_nettype wire

@@ src/ps2_set2_key_decoder.sv @@
// top level of the ps2 set 2 key decoder
// an accepted beat is registered in the queue, then in the output register, before out_valid rises
// throughput: one byte or tick per cycle while the queue has room; the back end retires one item per cycle
// a stalled output holds up the back end, the two-entry queue absorbs the front
// reset: asynchronous, clears modifiers, prefixes, repeat state; registers take 0, 1, 50, 10
`timescale 1ns / 1ps
`default_nettype none
module ps2_set2_key_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic        operation,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        from_aux,
	input  wire logic        line_error,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       event_kind,
	output logic [6:0]       event_value
);
	import ps2k_pkg::*;

	logic  f_valid, f_ready, b_valid, b_ready;
	item_t f_item, b_item;

	ps2k_front u_front (
		.clk, .arst_n, .valid, .ready, .operation, .rx_byte, .from_aux, .line_error,
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	ps2k_fifo u_fifo (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
	);

	ps2k_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.out_valid, .out_ready, .event_kind, .event_value
	);
endmodule
`default_nettype wire
